/* hdl/ftna_pkg.sv */
// ----------------------------------------------------------------------------
// Fat-tree address converter package
// Shared widths, node kinds, register indexes and the structs that travel
// between the pipeline parts.
// ----------------------------------------------------------------------------
package ftna_pkg;

  localparam int KW = 8;
  localparam int CW = 11;
  localparam int OW = 7;
  localparam int NW = 17;
  localparam int DW = 14;
  localparam int AW = 18;
  localparam int XW = 11;

  localparam logic [1:0] CFG_NUM_PODS      = 2'd0;
  localparam logic [1:0] CFG_NUM_CORE      = 2'd1;
  localparam logic [1:0] CFG_SWITCHES_POD  = 2'd2;

  typedef enum logic [1:0] {
    KIND_CORE   = 2'd0,
    KIND_AGG    = 2'd1,
    KIND_EDGE   = 2'd2,
    KIND_SERVER = 2'd3
  } kind_e;

  typedef struct packed {
    logic [KW-1:0] k;
    logic [KW-2:0] k2;
    logic [CW-1:0] c;
    logic [OW-1:0] h;
    logic [DW-1:0] s2;
    logic [DW-1:0] q;
    logic [DW-1:0] m;
    logic [AW-1:0] agg_end;
    logic [AW-1:0] srv_start;
    logic [NW-1:0] kh;
  } cfg_t;

  typedef struct packed {
    logic          func;
    logic [NW-1:0] node;
    logic [OW-1:0] pod;
    logic [OW-1:0] sw;
    logic [OW-1:0] host;
  } item_t;

  typedef struct packed {
    logic  valid;
    kind_e kind;
    item_t item;
  } stage_t;

endpackage

/* hdl/ftna_div.sv */
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per register stage, with a side word that travels along.
// ----------------------------------------------------------------------------
module ftna_div
  import ftna_pkg::*;
#(
  parameter int SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic [NW-1:0] quo_o,
  output logic [DW-1:0] rem_o,
  output logic [SW-1:0] side_o
);

  logic [NW-1:0] num_s  [0:NW];
  logic [DW-1:0] den_s  [0:NW];
  logic [DW-1:0] rem_s  [0:NW];
  logic [NW-1:0] quo_s  [0:NW];
  logic [SW-1:0] side_s [0:NW];

  assign num_s[0]  = num_i;
  assign den_s[0]  = den_i;
  assign rem_s[0]  = '0;
  assign quo_s[0]  = '0;
  assign side_s[0] = side_i;

  for (genvar i = 0; i < NW; i++) begin : g_stage
    logic [DW:0]   t;
    logic [DW:0]   diff;
    logic          ge;
    logic [NW-1:0] num_q;
    logic [DW-1:0] den_q;
    logic [DW-1:0] rem_q;
    logic [NW-1:0] quo_q;
    logic [SW-1:0] side_q;

    assign t    = {rem_s[i], num_s[i][NW-1-i]};
    assign ge   = t >= {1'b0, den_s[i]};
    assign diff = t - {1'b0, den_s[i]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        num_q  <= '0;
        den_q  <= '0;
        rem_q  <= '0;
        quo_q  <= '0;
        side_q <= '0;
      end else if (en_i) begin
        num_q  <= num_s[i];
        den_q  <= den_s[i];
        rem_q  <= ge ? diff[DW-1:0] : t[DW-1:0];
        quo_q  <= {quo_s[i][NW-2:0], ge};
        side_q <= side_s[i];
      end
    end

    assign num_s[i+1]  = num_q;
    assign den_s[i+1]  = den_q;
    assign rem_s[i+1]  = rem_q;
    assign quo_s[i+1]  = quo_q;
    assign side_s[i+1] = side_q;
  end

  assign quo_o  = quo_s[NW];
  assign rem_o  = rem_s[NW];
  assign side_o = side_s[NW];

endmodule

/* hdl/ftna_front.sv */
// ----------------------------------------------------------------------------
// Fat-tree address converter front stage
// Registers the input transfer, classifies the node and prepares the
// dividends, divisors and the address-to-node result.
// ----------------------------------------------------------------------------
module ftna_front
  import ftna_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic          func_i,
  input  logic [NW-1:0] node_id_i,
  input  logic [OW-1:0] pod_i,
  input  logic [OW-1:0] sw_i,
  input  logic [OW-1:0] host_i,
  input  cfg_t          cfg_i,
  output logic          valid_o,
  output kind_e         kind_o,
  output item_t         item_o,
  output logic [NW-1:0] num1_o,
  output logic [DW-1:0] den1_o,
  output logic [NW-1:0] num2_o,
  output logic [DW-1:0] den2_o
);

  logic          valid_q;
  logic          func_q;
  logic [NW-1:0] n_q;
  logic [OW-1:0] pod_q;
  logic [OW-1:0] sw_q;
  logic [OW-1:0] host_q;

  logic [AW-1:0] n_ext;
  logic [AW-1:0] d_core;
  logic [AW-1:0] d_agg;
  logic [AW-1:0] d_srv;
  logic [NW-1:0] pq;
  logic [NW-1:0] swh;
  logic [NW-1:0] podh;
  logic [NW-1:0] node_a;
  kind_e         kind_n;
  kind_e         kind_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      func_q <= func_i;
      n_q    <= node_id_i;
      pod_q  <= pod_i;
      sw_q   <= sw_i;
      host_q <= host_i;
    end
  end

  assign n_ext  = AW'(n_q);
  assign d_core = n_ext - AW'(cfg_i.c);
  assign d_agg  = n_ext - cfg_i.agg_end;
  assign d_srv  = n_ext - cfg_i.srv_start;

  assign pq   = NW'(pod_q) * NW'(cfg_i.q);
  assign swh  = NW'(sw_q) * NW'(cfg_i.h);
  assign podh = NW'(pod_q) * NW'(cfg_i.h);

  always_comb begin
    if (n_ext < AW'(cfg_i.c)) begin
      kind_n = KIND_CORE;
    end else if (n_ext < cfg_i.agg_end) begin
      kind_n = KIND_AGG;
    end else if (n_ext < cfg_i.srv_start) begin
      kind_n = KIND_EDGE;
    end else begin
      kind_n = KIND_SERVER;
    end
  end

  always_comb begin
    if (KW'(pod_q) == cfg_i.k) begin
      kind_a = KIND_CORE;
      node_a = swh - NW'(cfg_i.h) + NW'(host_q) - NW'(1);
    end else if (host_q != OW'(1)) begin
      kind_a = KIND_SERVER;
      node_a = cfg_i.srv_start[NW-1:0] + pq + swh + NW'(host_q) - NW'(2);
    end else if (sw_q >= cfg_i.k2) begin
      kind_a = KIND_AGG;
      node_a = NW'(cfg_i.c) + podh + NW'(sw_q) - NW'(cfg_i.k2);
    end else begin
      kind_a = KIND_EDGE;
      node_a = NW'(cfg_i.c) + podh + cfg_i.kh + NW'(sw_q);
    end
  end

  always_comb begin
    unique case (kind_n)
      KIND_CORE: begin
        num1_o = n_q;
        den1_o = DW'(cfg_i.h);
      end
      KIND_AGG, KIND_EDGE: begin
        num1_o = d_core[NW-1:0];
        den1_o = cfg_i.m;
      end
      KIND_SERVER: begin
        num1_o = d_srv[NW-1:0];
        den1_o = cfg_i.q;
      end
    endcase
  end

  assign num2_o = (kind_n == KIND_AGG) ? d_core[NW-1:0] : d_agg[NW-1:0];
  assign den2_o = cfg_i.s2;

  assign valid_o     = valid_q;
  assign kind_o      = func_q ? kind_a : kind_n;
  assign item_o.func = func_q;
  assign item_o.node = func_q ? node_a : n_q;
  assign item_o.pod  = pod_q;
  assign item_o.sw   = sw_q;
  assign item_o.host = host_q;

endmodule

/* hdl/ftna_mid.sv */
// ----------------------------------------------------------------------------
// Fat-tree address converter middle step
// Takes the first quotients, settles the pod and core fields and feeds the
// column divider.
// ----------------------------------------------------------------------------
module ftna_mid
  import ftna_pkg::*;
(
  input  logic          valid_i,
  input  item_t         item_i,
  input  kind_e         kind_i,
  input  logic [NW-1:0] quo1_i,
  input  logic [DW-1:0] rem1_i,
  input  logic [NW-1:0] quo2_i,
  input  cfg_t          cfg_i,
  output stage_t        stage_o,
  output logic [NW-1:0] num3_o,
  output logic [DW-1:0] den3_o
);

  always_comb begin
    stage_o.valid = valid_i;
    stage_o.kind  = kind_i;
    stage_o.item  = item_i;
    if (!item_i.func) begin
      unique case (kind_i)
        KIND_CORE: begin
          stage_o.item.pod  = cfg_i.k[OW-1:0];
          stage_o.item.sw   = quo1_i[OW-1:0] + OW'(1);
          stage_o.item.host = rem1_i[OW-1:0] + OW'(1);
        end
        KIND_AGG, KIND_EDGE: begin
          stage_o.item.pod = quo2_i[OW-1:0];
        end
        KIND_SERVER: begin
          stage_o.item.pod = quo1_i[OW-1:0];
        end
      endcase
    end
  end

  assign num3_o = NW'(rem1_i);
  assign den3_o = DW'(cfg_i.h);

endmodule

/* hdl/ftna_back.sv */
// ----------------------------------------------------------------------------
// Fat-tree address converter output stage
// Forms the switch and host octets from the column divider and holds the
// result transfer in the output register.
// ----------------------------------------------------------------------------
module ftna_back
  import ftna_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  stage_t        stage_i,
  input  logic [NW-1:0] quo3_i,
  input  logic [DW-1:0] rem3_i,
  input  cfg_t          cfg_i,
  output logic          valid_o,
  output logic [1:0]    kind_o,
  output logic [NW-1:0] node_o,
  output logic [OW-1:0] pod_o,
  output logic [OW-1:0] sw_o,
  output logic [OW-1:0] host_o,
  output logic [OW-1:0] pidx_o
);

  logic          valid_q;
  logic [1:0]    kind_q;
  logic [NW-1:0] node_q;
  logic [OW-1:0] pod_q;
  logic [OW-1:0] sw_q;
  logic [OW-1:0] host_q;
  logic [OW-1:0] pidx_q;

  logic [OW-1:0] sw_d;
  logic [OW-1:0] host_d;
  logic [OW-1:0] pidx_d;

  always_comb begin
    sw_d   = stage_i.item.sw;
    host_d = stage_i.item.host;
    pidx_d = '1;
    unique case (stage_i.kind)
      KIND_CORE: begin
      end
      KIND_AGG: begin
        pidx_d = stage_i.item.pod;
        if (!stage_i.item.func) begin
          sw_d   = rem3_i[OW-1:0] + cfg_i.k2;
          host_d = OW'(1);
        end
      end
      KIND_EDGE: begin
        pidx_d = stage_i.item.pod;
        if (!stage_i.item.func) begin
          sw_d   = rem3_i[OW-1:0];
          host_d = OW'(1);
        end
      end
      KIND_SERVER: begin
        if (!stage_i.item.func) begin
          sw_d   = quo3_i[OW-1:0];
          host_d = rem3_i[OW-1:0] + OW'(2);
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= stage_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      kind_q <= stage_i.kind;
      node_q <= stage_i.item.node;
      pod_q  <= stage_i.item.pod;
      sw_q   <= sw_d;
      host_q <= host_d;
      pidx_q <= pidx_d;
    end
  end

  assign valid_o = valid_q;
  assign kind_o  = kind_q;
  assign node_o  = node_q;
  assign pod_o   = pod_q;
  assign sw_o    = sw_q;
  assign host_o  = host_q;
  assign pidx_o  = pidx_q;

endmodule

/* hdl/fat_tree_node_address_convert.sv */
// ----------------------------------------------------------------------------
// Fat-tree node address converter
// Converts flat node numbers to k-ary fat-tree addresses and back, and
// reports the node kind and pod index of every item.
//
//   Channel  Signals                                Direction
//   in       in_valid_i / in_stall_o + 5 fields     into the block
//   out      out_valid_o / out_stall_i + 6 fields   out of the block
//   cfg      cfg_we_i, cfg_idx_i, cfg_wdata_i        into the block
//
// One transfer is taken per cycle unless the output stalls; each item passes
// the input register, two chained 17-stage dividers and the output register.
// Reset loads pod count 4, core count 4 and switches per pod 4.
// A stalled result freezes the whole pipeline, so nothing is lost.
// ----------------------------------------------------------------------------
module fat_tree_node_address_convert
  import ftna_pkg::*;
#(
  parameter int MAX_PODS = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [XW-1:0]        cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 func_i,
  input  logic [NW-1:0]        node_id_i,
  input  logic [OW-1:0]        in_pod_i,
  input  logic [OW-1:0]        in_switch_i,
  input  logic [OW-1:0]        in_host_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [1:0]           node_kind_o,
  output logic [NW-1:0]        out_node_id_o,
  output logic [OW-1:0]        out_pod_o,
  output logic [OW-1:0]        out_switch_o,
  output logic [OW-1:0]        out_host_o,
  output logic signed [OW-1:0] pod_index_o
);

  logic [OW-1:0] pods_q;
  logic [CW-1:0] cores_q;
  logic [OW-1:0] spp_q;
  cfg_t          cfg_d;
  cfg_t          cfg_q;

  logic [KW-1:0]   k_c;
  logic [KW-2:0]   k2_c;
  logic [OW-2:0]   s_half;
  logic [2*KW-1:0] kk;
  logic [KW+OW-1:0] ks;
  logic [KW+OW-1:0] ksh;
  logic [DW-1:0]   q_raw;
  logic [DW-1:0]   m_raw;
  logic [2*KW-1:0] kh_c;

  logic          en;
  logic          f_valid;
  kind_e         f_kind;
  item_t         f_item;
  logic [NW-1:0] num1;
  logic [DW-1:0] den1;
  logic [NW-1:0] num2;
  logic [DW-1:0] den2;
  logic [NW-1:0] quo1;
  logic [DW-1:0] rem1;
  logic [NW-1:0] quo2;
  logic [DW-1:0] rem2_unused;
  logic [$bits(item_t):0] side1;
  logic [1:0]    side2;
  stage_t        mid_stage;
  logic [NW-1:0] num3;
  logic [DW-1:0] den3;
  logic [NW-1:0] quo3;
  logic [DW-1:0] rem3;
  stage_t        d3_stage;
  logic [OW-1:0] pidx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pods_q  <= OW'(4);
      cores_q <= CW'(4);
      spp_q   <= OW'(4);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_NUM_PODS:     pods_q  <= cfg_wdata_i[OW-1:0];
        CFG_NUM_CORE:     cores_q <= cfg_wdata_i[CW-1:0];
        CFG_SWITCHES_POD: spp_q   <= cfg_wdata_i[OW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign k_c    = (KW'(pods_q) > KW'(MAX_PODS)) ? KW'(MAX_PODS) : KW'(pods_q);
  assign k2_c   = k_c[KW-1:1];
  assign s_half = spp_q[OW-1:1];
  assign kk     = {{KW{1'b0}}, k_c} * {{KW{1'b0}}, k_c};
  assign ks     = {{OW{1'b0}}, k_c} * {{KW{1'b0}}, spp_q};
  assign ksh    = {{OW{1'b0}}, k_c} * {{(KW+1){1'b0}}, s_half};
  assign q_raw  = kk[DW+1:2];
  assign m_raw  = ks[DW:1];

  always_comb begin
    cfg_d.k         = k_c;
    cfg_d.k2        = k2_c;
    cfg_d.c         = cores_q;
    cfg_d.h         = (k2_c == '0) ? OW'(1) : OW'(k2_c);
    cfg_d.s2        = (s_half == '0) ? DW'(1) : DW'(s_half);
    cfg_d.q         = (q_raw == '0) ? DW'(1) : q_raw;
    cfg_d.m         = (m_raw == '0) ? DW'(1) : m_raw;
    cfg_d.agg_end   = AW'(cores_q) + AW'(ksh);
    cfg_d.srv_start = AW'(cores_q) + AW'(ks);
    cfg_d.kh        = NW'(kh_c);
  end

  assign kh_c = {{KW{1'b0}}, k_c} *
                {{(KW+1){1'b0}}, ((k2_c == '0) ? OW'(1) : OW'(k2_c))};

  always_ff @(posedge clk_i) begin
    cfg_q <= cfg_d;
  end

  assign en         = !out_valid_o || !out_stall_i;
  assign in_stall_o = !en;

  ftna_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (in_valid_i),
    .func_i    (func_i),
    .node_id_i (node_id_i),
    .pod_i     (in_pod_i),
    .sw_i      (in_switch_i),
    .host_i    (in_host_i),
    .cfg_i     (cfg_q),
    .valid_o   (f_valid),
    .kind_o    (f_kind),
    .item_o    (f_item),
    .num1_o    (num1),
    .den1_o    (den1),
    .num2_o    (num2),
    .den2_o    (den2)
  );

  ftna_div #(
    .SW ($bits(item_t) + 1)
  ) u_div1 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .num_i  (num1),
    .den_i  (den1),
    .side_i ({f_valid, f_item}),
    .quo_o  (quo1),
    .rem_o  (rem1),
    .side_o (side1)
  );

  ftna_div #(
    .SW (2)
  ) u_div2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .num_i  (num2),
    .den_i  (den2),
    .side_i (f_kind),
    .quo_o  (quo2),
    .rem_o  (rem2_unused),
    .side_o (side2)
  );

  ftna_mid u_mid (
    .valid_i (side1[$bits(item_t)] & (rem2_unused == rem2_unused)),
    .item_i  (side1[$bits(item_t)-1:0]),
    .kind_i  (kind_e'(side2)),
    .quo1_i  (quo1),
    .rem1_i  (rem1),
    .quo2_i  (quo2),
    .cfg_i   (cfg_q),
    .stage_o (mid_stage),
    .num3_o  (num3),
    .den3_o  (den3)
  );

  ftna_div #(
    .SW ($bits(stage_t))
  ) u_div3 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .num_i  (num3),
    .den_i  (den3),
    .side_i (mid_stage),
    .quo_o  (quo3),
    .rem_o  (rem3),
    .side_o (d3_stage)
  );

  ftna_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .stage_i (d3_stage),
    .quo3_i  (quo3),
    .rem3_i  (rem3),
    .cfg_i   (cfg_q),
    .valid_o (out_valid_o),
    .kind_o  (node_kind_o),
    .node_o  (out_node_id_o),
    .pod_o   (out_pod_o),
    .sw_o    (out_switch_o),
    .host_o  (out_host_o),
    .pidx_o  (pidx)
  );

  assign pod_index_o = $signed(pidx);

endmodule
